/* rtl/core/o3csp_pkg.sv */
// ----------------------------------------------------------------------------
// o3csp_pkg
// Shared types, constants and helper functions of the order-3 context
// symbol predictor.
// ----------------------------------------------------------------------------
package o3csp_pkg;

  // Default sizes of the counter store.
  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned CONTEXT_COUNT = 64;

  // Nucleotide codes.
  localparam logic [1:0] NUC_A = 2'd0;
  localparam logic [1:0] NUC_C = 2'd1;
  localparam logic [1:0] NUC_G = 2'd2;
  localparam logic [1:0] NUC_T = 2'd3;

  // ASCII letters, upper and lower case.
  localparam logic [7:0] CHAR_A_UC = 8'd65;
  localparam logic [7:0] CHAR_C_UC = 8'd67;
  localparam logic [7:0] CHAR_G_UC = 8'd71;
  localparam logic [7:0] CHAR_T_UC = 8'd84;
  localparam logic [7:0] CHAR_A_LC = 8'd97;
  localparam logic [7:0] CHAR_C_LC = 8'd99;
  localparam logic [7:0] CHAR_G_LC = 8'd103;
  localparam logic [7:0] CHAR_T_LC = 8'd116;

  // Where the counter row of the current context comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_BYP
  } win_src_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       coded_flag;
    logic [1:0] coded_symbol;
    logic       last_item;
  } in_word_t;

  typedef struct packed {
    logic       miss_flag;
    logic [1:0] symbol;
    logic [7:0] char_out;
  } out_word_t;

  // Returns {valid, code}; valid is low for a byte that is no nucleotide letter.
  function automatic logic [2:0] letter_code(input logic [7:0] b);
    logic [2:0] res;
    case (b)
      CHAR_A_UC, CHAR_A_LC: res = {1'b1, NUC_A};
      CHAR_C_UC, CHAR_C_LC: res = {1'b1, NUC_C};
      CHAR_G_UC, CHAR_G_LC: res = {1'b1, NUC_G};
      CHAR_T_UC, CHAR_T_LC: res = {1'b1, NUC_T};
      default:              res = 3'b000;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] nuc_letter(input logic [1:0] sym);
    logic [7:0] res;
    case (sym)
      NUC_A:   res = CHAR_A_UC;
      NUC_C:   res = CHAR_C_UC;
      NUC_G:   res = CHAR_G_UC;
      NUC_T:   res = CHAR_T_UC;
      default: res = CHAR_A_UC;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/o3csp_ram.sv */
// ----------------------------------------------------------------------------
// o3csp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module o3csp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/order3_context_symbol_predictor.sv */
// ----------------------------------------------------------------------------
// order3_context_symbol_predictor
// Order-3 nucleotide context predictor with saturating frequency counters.
// ----------------------------------------------------------------------------
// Usage: input words arrive on in_valid_i/in_ready_o and carry a character
// (encode mode) or a flag and symbol (decode mode) plus a last-item marker.
// Each accepted word that names a nucleotide gives one result word on
// out_valid_o/out_ready_i: miss flag, symbol and its upper-case letter. A
// non-nucleotide byte in encode mode gives no result. cfg_we_i writes the
// mode bit; the user must do so only while the block is idle, which the block
// does not enforce. Throughput is one word per cycle while in_ready_o is high;
// results are registered. Counters live in a RAM in rows of four contexts,
// so the row of the next context is read while the current word is worked on.
// A two-deep output buffer keeps the input open while one result waits; with
// both entries full, in_ready_o drops until the receiver takes a word.
// Reset and a last-item word clear all counters and the context at once
// through per-row valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module order3_context_symbol_predictor #(
  parameter int unsigned COUNT_WIDTH   = o3csp_pkg::COUNT_WIDTH,
  parameter int unsigned CONTEXT_COUNT = o3csp_pkg::CONTEXT_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  o3csp_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output o3csp_pkg::out_word_t out_data_o
);

  localparam int unsigned CTX_W     = $clog2(CONTEXT_COUNT);
  localparam int unsigned ROW_COUNT = CONTEXT_COUNT / 4;
  localparam int unsigned ROW_AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned ROW_W     = 16 * COUNT_WIDTH;

  typedef logic [3:0][3:0][COUNT_WIDTH-1:0] row_t;

  logic                 mode_q;
  logic [CTX_W-1:0]     ctx_q, ctx_d;
  o3csp_pkg::win_src_e  src_q, src_d;
  row_t                 byp_q, byp_d;
  logic [ROW_COUNT-1:0] row_valid_q, row_valid_d;

  logic                 out_valid_q, skid_valid_q;
  o3csp_pkg::out_word_t out_q, skid_q;

  logic                 in_fire, out_fire;
  logic [ROW_W-1:0]     ram_rdata;
  logic                 ram_we, ram_re;
  logic [ROW_AW-1:0]    row_cur, row_next;
  logic [1:0]           slot;
  row_t                 win, upd;
  logic [3:0][COUNT_WIDTH-1:0] cnt;
  logic [1:0]           pred, sym;
  logic [2:0]           lcode;
  logic                 sym_ok;
  o3csp_pkg::out_word_t res;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Row of the current context, and the row that holds all four possible
  // next contexts (it depends only on the low bits of the current context).
  assign row_cur  = (ROW_COUNT > 1) ? ROW_AW'(ctx_q >> 2) : '0;
  assign row_next = (ROW_COUNT > 1) ? ROW_AW'(ctx_q) : '0;
  assign slot     = ctx_q[1:0];

  always_comb begin
    case (src_q)
      o3csp_pkg::SRC_ZERO: win = '0;
      o3csp_pkg::SRC_MEM:  win = row_t'(ram_rdata);
      o3csp_pkg::SRC_BYP:  win = byp_q;
      default:             win = '0;
    endcase
  end

  assign cnt = win[slot];

  // Largest count wins; a strict compare keeps the lowest index on a tie.
  always_comb begin
    logic [COUNT_WIDTH-1:0] best_n;
    pred   = o3csp_pkg::NUC_A;
    best_n = cnt[0];
    for (int i = 1; i < 4; i++) begin
      if (cnt[i] > best_n) begin
        pred   = 2'(i);
        best_n = cnt[i];
      end
    end
  end

  assign lcode = o3csp_pkg::letter_code(in_data_i.char_byte);

  always_comb begin
    if (mode_q) begin
      sym    = in_data_i.coded_flag ? in_data_i.coded_symbol : pred;
      sym_ok = 1'b1;
    end else begin
      sym    = lcode[1:0];
      sym_ok = lcode[2];
    end
  end

  always_comb begin
    upd = win;
    if (cnt[sym] != {COUNT_WIDTH{1'b1}}) begin
      upd[slot][sym] = cnt[sym] + COUNT_WIDTH'(1);
    end
  end

  assign res.miss_flag = (sym != pred);
  assign res.symbol    = sym;
  assign res.char_out  = o3csp_pkg::nuc_letter(sym);

  // Next context, row source and row flags.
  always_comb begin
    ctx_d       = ctx_q;
    src_d       = src_q;
    byp_d       = byp_q;
    row_valid_d = row_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (in_fire) begin
      if (in_data_i.last_item) begin
        ctx_d       = '0;
        src_d       = o3csp_pkg::SRC_ZERO;
        row_valid_d = '0;
      end else if (sym_ok) begin
        ctx_d                = CTX_W'({ctx_q, sym});
        ram_we               = 1'b1;
        row_valid_d[row_cur] = 1'b1;
        if (row_next == row_cur) begin
          // The RAM still holds the old row this cycle, so forward it.
          byp_d = upd;
          src_d = o3csp_pkg::SRC_BYP;
        end else if (row_valid_q[row_next]) begin
          ram_re = 1'b1;
          src_d  = o3csp_pkg::SRC_MEM;
        end else begin
          src_d = o3csp_pkg::SRC_ZERO;
        end
      end else begin
        byp_d = win;
        src_d = o3csp_pkg::SRC_BYP;
      end
    end
  end

  o3csp_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROW_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row_cur),
    .wdata_i(ROW_W'(upd)),
    .re_i   (ram_re),
    .raddr_i(row_next),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      ctx_q       <= '0;
      src_q       <= o3csp_pkg::SRC_ZERO;
      row_valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      ctx_q       <= ctx_d;
      src_q       <= src_d;
      row_valid_q <= row_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= byp_d;
  end

  // Two-deep output buffer: main register plus skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire && sym_ok;
        end
      end else if (in_fire && sym_ok) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire && sym_ok) begin
      if (!out_valid_q) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
